// ===== sv/rpn_stack_calculator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RPN stack calculator core
// Concurrent checks clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`define RPN_STACK_CALCULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpn assertion failed");

// next-cycle implication
`define RPN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpn assertion failed");

`endif

// ===== sv/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and sizes for the RPN stack calculator core.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BAD   = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         depth;
    logic [2:0]         status;
  } rsp_item_t;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_PUSH,
    CK_RESULT
  } commit_kind_t;

  typedef struct packed {
    logic         load;
    logic         ram_rd;
    logic         addsub;
    logic         mul_start;
    logic         mul_round;
    logic         div_init;
    logic         div_step;
    logic         div_fin;
    logic         commit;
    commit_kind_t kind;
    logic [2:0]   code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       lt2;
    logic       top_zero;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ===== sv/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer: decodes each beat, steps the arithmetic unit, commits results.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rpn_pkg::dp_stat_t stat,
  output rpn_pkg::dp_cmd_t  cmd
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_MUL,
    S_DIV,
    S_DIVFIN,
    S_DONE
  } state_t;

  state_t                 state;
  commit_kind_t           kind;
  logic [2:0]             code;
  logic [DIV_CNT_W-1:0]   div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      kind    <= CK_HOLD;
      code    <= ST_OK;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          kind  <= CK_HOLD;
          code  <= ST_OK;
          if (stat.op == OP_PUSH) begin
            if (stat.full) begin
              code <= ST_FULL;
            end else begin
              kind <= CK_PUSH;
            end
          end else if (stat.op > OP_DIV) begin
            code <= ST_BAD;
          end else if (stat.lt2) begin
            code <= ST_UNDER;
          end else if (stat.op == OP_DIV && stat.top_zero) begin
            code <= ST_DIVZ;
          end else begin
            kind  <= CK_RESULT;
            state <= S_READ;
          end
        end
        S_READ: begin
          case (stat.op)
            OP_ADD, OP_SUB: state <= S_DONE;
            OP_MUL:         state <= S_MUL;
            default: begin
              state   <= S_DIV;
              div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            end
          endcase
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_DIVFIN;
          end else begin
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end
        S_DIVFIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.kind = kind;
    cmd.code = code;
    case (state)
      S_IDLE:   cmd.load   = req_valid;
      S_DECODE: cmd.ram_rd = 1'b1;
      S_READ: begin
        case (stat.op)
          OP_ADD, OP_SUB: cmd.addsub    = 1'b1;
          OP_MUL:         cmd.mul_start = 1'b1;
          default:        cmd.div_init  = 1'b1;
        endcase
      end
      S_MUL:    cmd.mul_round = 1'b1;
      S_DIV:    cmd.div_step  = 1'b1;
      S_DIVFIN: cmd.div_fin   = 1'b1;
      S_DONE:   cmd.commit    = !stat.out_busy;
      default:  cmd.commit    = 1'b0;
    endcase
  end

endmodule

// ===== sv/rpn_dpath.sv =====
// ----------------------------------------------------------------------------
// rpn_dpath
// Stack storage (cached top plus RAM below), arithmetic unit, output register.
// ----------------------------------------------------------------------------
module rpn_dpath (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rpn_pkg::rsp_item_t rsp,
  input  rpn_pkg::dp_cmd_t   cmd,
  output rpn_pkg::dp_stat_t  stat
);
  import rpn_pkg::*;

  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic signed [31:0] top;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] res;
  logic               sat;
  logic signed [63:0] prod;

  // divider
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvsr;
  logic        neg;
  logic        big;

  logic [31:0]        ram_rdata;
  logic signed [31:0] left;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic               ram_we;

  assign left   = ram_rdata;
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);

  rpn_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_m1[ADDR_W-1:0]),
    .wdata(top),
    .re   (cmd.ram_rd),
    .raddr(cnt_m2[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign stat.op       = op_r;
  assign stat.full     = (count == CNT_W'(STACK_DEPTH));
  assign stat.lt2      = (count < CNT_W'(2));
  assign stat.top_zero = (top == '0);
  assign stat.out_busy = rsp_valid && !rsp_ready;

  // add / subtract
  logic signed [32:0] as_sum;
  always_comb begin
    if (op_r == OP_SUB) begin
      as_sum = {left[31], left} - {top[31], top};
    end else begin
      as_sum = {left[31], left} + {top[31], top};
    end
  end

  // multiply rounding: floor((p + 2^15) / 2^16)
  logic signed [63:0] mul_w;
  logic signed [63:0] rsum;
  logic signed [47:0] rsh;
  logic               mul_fits;
  assign mul_w    = left * top;
  assign rsum     = prod + 64'sd32768;
  assign rsh      = rsum[63:16];
  assign mul_fits = (&rsh[47:31]) || !(|rsh[47:31]);

  // divide setup: magnitudes, overflow when |l| >= |r| * 2^16
  logic [31:0] lu;
  logic [31:0] ru;
  logic [31:0] al;
  logic [31:0] ar;
  assign lu = left;
  assign ru = top;
  assign al = lu[31] ? (32'd0 - lu) : lu;
  assign ar = ru[31] ? (32'd0 - ru) : ru;

  logic [32:0] trial;
  logic        take;
  assign trial = {rem, quo[31]};
  assign take  = (trial >= {1'b0, dvsr});

  // commit
  logic signed [31:0] new_top;
  logic [CNT_W-1:0]   new_count;
  logic [2:0]         new_status;
  always_comb begin
    new_top    = top;
    new_count  = count;
    new_status = cmd.code;
    ram_we     = 1'b0;
    case (cmd.kind)
      CK_PUSH: begin
        new_top    = val_r;
        new_count  = count + CNT_W'(1);
        new_status = ST_OK;
        ram_we     = cmd.commit && (count != '0);
      end
      CK_RESULT: begin
        new_top    = res;
        new_count  = cnt_m1;
        new_status = sat ? ST_SAT : ST_OK;
      end
      default: begin
        new_top = top;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= new_count;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req.operation;
      val_r <= req.value;
    end
    if (cmd.commit) begin
      top           <= new_top;
      rsp.top_value <= (new_count != '0) ? new_top : 32'sd0;
      rsp.depth     <= 5'(new_count);
      rsp.status    <= new_status;
    end
    if (cmd.addsub) begin
      sat <= (as_sum[32] != as_sum[31]);
      if (as_sum[32] != as_sum[31]) begin
        res <= as_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        res <= as_sum[31:0];
      end
    end
    if (cmd.mul_start) begin
      prod <= mul_w;
    end
    if (cmd.mul_round) begin
      sat <= !mul_fits;
      if (mul_fits) begin
        res <= rsh[31:0];
      end else begin
        res <= rsh[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
    end
    if (cmd.div_init) begin
      neg  <= lu[31] ^ ru[31];
      big  <= ({16'd0, al} >= {ar, 16'd0});
      rem  <= {16'd0, al[31:16]};
      quo  <= {al[15:0], 16'd0};
      dvsr <= ar;
    end
    if (cmd.div_step) begin
      rem <= take ? 32'(trial - {1'b0, dvsr}) : trial[31:0];
      quo <= {quo[30:0], take};
    end
    if (cmd.div_fin) begin
      if (big) begin
        sat <= 1'b1;
        res <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (!neg) begin
        sat <= quo[31];
        res <= quo[31] ? 32'sh7fff_ffff : quo;
      end else if (quo > 32'h8000_0000) begin
        sat <= 1'b1;
        res <= 32'sh8000_0000;
      end else begin
        sat <= 1'b0;
        res <= 32'd0 - quo;
      end
    end
  end

endmodule

// ===== sv/rpn_stack_calculator_core.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Each accepted beat is decoded; push and errors then commit, add and subtract
// pass through S_READ first, multiply through S_READ and S_MUL, and divide through
// S_READ, the 32 steps of the restoring divider and S_DIVFIN. One beat in flight;
// the next is taken the cycle after the result is loaded into the output register.
// Synchronous reset empties the stack; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rpn_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rpn_pkg::rsp_item_t rsp
);
  import rpn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== sv/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks for the RPN stack calculator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_core_assert.svh"

module rpn_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input rpn_pkg::rsp_item_t rsp
);
  import rpn_pkg::*;

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  `RPN_ASSERT_IMP(a_empty_top_zero, rsp_valid && rsp.depth == 5'd0, rsp.top_value == 32'sd0)
  `RPN_ASSERT_IMP(a_under_depth, rsp_valid && rsp.status == ST_UNDER, rsp.depth < 5'd2)
  `RPN_ASSERT_IMP(a_full_depth, rsp_valid && rsp.status == ST_FULL,
                  rsp.depth == 5'(STACK_DEPTH))
  `RPN_ASSERT_NXT(a_one_in_flight, req_acc, !req_ready)
  `RPN_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (.*);

// ===== verif/rpn_stack_calculator_core_tb.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core_tb
// Drives push and arithmetic beats into the RPN calculator core and checks
// every response against a Q16.16 stack predictor kept in the bench. Covers
// underflow, bad op codes, full stack, divide by zero, saturation, random
// well-formed op streams with some noise, and a long response stall.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core_tb;
  import rpn_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_WAIT  = 50;
  localparam int          MAX_REPORTS = 200;
  localparam logic [2:0]  OP_BAD_MIN  = OP_DIV + 3'd1;
  localparam logic [2:0]  OP_BAD_MAX  = 3'd7;
  localparam longint      Q_MAX       = 64'sd2147483647;
  localparam longint      Q_MIN       = -64'sd2147483648;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  rsp_item_t         pending_rsp [$];
  logic signed [31:0] stack_img [STACK_DEPTH];
  int unsigned       stack_fill = 0;
  int                mismatches = 0;
  int                cycle_cnt  = 0;

  // response stall control
  int        hold_len = 0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_left = 0;
  int        rx_mode = 0;
  int        mode_left = 0;
  logic [7:0] rx_pat = 8'b1011_0010;

  rpn_stack_calculator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic logic signed [31:0] sat_q16(input longint wide, output bit hit);
    hit = 1'b1;
    if (wide > Q_MAX) return 32'sh7fff_ffff;
    if (wide < Q_MIN) return 32'sh8000_0000;
    hit = 1'b0;
    return wide[31:0];
  endfunction

  // applies one beat to the stack image, returns the response it should give
  function automatic rsp_item_t rpn_apply(input req_item_t b);
    rsp_item_t r;
    longint    lhs;
    longint    rhs;
    longint    wide;
    bit        hit;
    r.status = ST_OK;
    if (b.operation == OP_PUSH) begin
      if (stack_fill >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        stack_img[ADDR_W'(stack_fill)] = b.value;
        stack_fill++;
      end
    end else if (b.operation > OP_DIV) begin
      r.status = ST_BAD;
    end else if (stack_fill < 2) begin
      r.status = ST_UNDER;
    end else begin
      rhs  = stack_img[ADDR_W'(stack_fill - 1)];
      lhs  = stack_img[ADDR_W'(stack_fill - 2)];
      wide = 0;
      case (b.operation)
        OP_ADD:  wide = lhs + rhs;
        OP_SUB:  wide = lhs - rhs;
        OP_MUL:  wide = (lhs * rhs + 64'sd32768) >>> 16;
        default: if (rhs != 0) wide = (lhs * 64'sd65536) / rhs;
      endcase
      if (b.operation == OP_DIV && rhs == 0) begin
        r.status = ST_DIVZ;
      end else begin
        stack_img[ADDR_W'(stack_fill - 2)] = sat_q16(wide, hit);
        stack_fill--;
        r.status = hit ? ST_SAT : ST_OK;
      end
    end
    r.top_value = (stack_fill > 0) ? stack_img[ADDR_W'(stack_fill - 1)] : 32'sd0;
    r.depth     = 5'(stack_fill);
    return r;
  endfunction

  function automatic req_item_t mk_beat(input logic [2:0] op, input logic signed [31:0] val);
    req_item_t b;
    b.operation = op;
    b.value     = val;
    return b;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return 32'h1 << $urandom_range(0, 31);
      4, 5, 6: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
      7:       return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed RPN with a little noise
  function automatic req_item_t pick_beat();
    req_item_t b;
    int        roll;
    logic [2:0] arith;
    b.value = pick_value();
    roll    = $urandom_range(0, 99);
    arith   = OP_ADD + 3'($urandom_range(0, 3));
    if (roll < 4) begin
      b.operation = 3'($urandom_range(OP_BAD_MIN, OP_BAD_MAX));
    end else if (roll < 8) begin
      b.operation = arith;
    end else if (roll < 10 || (stack_fill == STACK_DEPTH && roll < 20)) begin
      b.operation = OP_PUSH;
    end else if (stack_fill < 2) begin
      b.operation = OP_PUSH;
    end else if (stack_fill == STACK_DEPTH) begin
      b.operation = arith;
    end else begin
      b.operation = $urandom_range(0, 1) ? OP_PUSH : arith;
    end
    return b;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still up
  task automatic send_beat(input req_item_t b);
    rsp_item_t exp_rsp;
    req       <= b;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    exp_rsp     = rpn_apply(b);
    pending_rsp = {pending_rsp, exp_rsp};
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic test_underflow_and_bad_ops();
    send_beat(mk_beat(OP_ADD, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sh7fff_ffff));
    send_beat(mk_beat(OP_MUL, 32'sd0));
    send_beat(mk_beat(OP_BAD_MIN, 32'sh8000_0000));
    send_beat(mk_beat(OP_BAD_MAX, 32'shffff_ffff));
    idle_sender(2);
  endtask

  task automatic test_arith_saturation();
    send_beat(mk_beat(OP_PUSH, 32'sh0001_0000));
    send_beat(mk_beat(OP_ADD, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sh8000_0000));
    send_beat(mk_beat(OP_SUB, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sh8000_0000));
    send_beat(mk_beat(OP_ADD, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sd0));
    send_beat(mk_beat(OP_DIV, 32'sd0));
    send_beat(mk_beat(OP_SUB, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sh8000_0000));
    send_beat(mk_beat(OP_MUL, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'shffff_ffff));
    send_beat(mk_beat(OP_DIV, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'shffff_ffff));
    send_beat(mk_beat(OP_DIV, 32'sd0));
    send_beat(mk_beat(OP_PUSH, 32'sh8000_0000));
    send_beat(mk_beat(OP_MUL, 32'sd0));
    send_beat(mk_beat(3'(OP_BAD_MIN + 3'd1), 32'sd0));
    idle_sender(3);
  endtask

  task automatic test_stack_full();
    while (stack_fill < STACK_DEPTH) send_beat(mk_beat(OP_PUSH, pick_value()));
    send_beat(mk_beat(OP_PUSH, 32'sh1234_5678));
    idle_sender(1);
  endtask

  task automatic test_random_mix(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      while (burst > 0 && sent < n_items) begin
        send_beat(pick_beat());
        sent++;
        burst--;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 4));
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_len = 400;
    hold_req++;
    @(negedge clk);
    repeat (12) send_beat(pick_beat());
    idle_sender(1);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
      rx_pat    = 8'($urandom) | 8'h01;
    end
    mode_left--;
    rx_pat = {rx_pat[6:0], rx_pat[7]};
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= 1'($urandom_range(0, 1));
        2:       rsp_ready <= rx_pat[0];
        default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("unexpected response beat: %p", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.top_value !== want.top_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("top_value: expected %0d, got %0d", want.top_value, rsp.top_value);
        end
        if (rsp.depth !== want.depth) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("depth: expected %0d, got %0d", want.depth, rsp.depth);
        end
        if (rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("status: expected %0d, got %0d", want.status, rsp.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_underflow_and_bad_ops();
    test_arith_saturation();
    test_stack_full();
    test_random_mix(950);
    test_output_backpressure();
    test_random_mix(950);

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_ctrl.sv
sv/rpn_dpath.sv
sv/rpn_stack_calculator_core.sv
sv/rpn_checker.sv
verif/rpn_stack_calculator_core_tb.sv
